/* design/shs_pkg.sv */
// ----------------------------------------------------------------------------
// shs_pkg: shared constants and types for the scrambled Halton sampler
// Widths, table sizes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int PRIME_COUNT   = 1229;
    localparam int INDEX_BITS    = 48;
    localparam int FRACTION_BITS = 32;
    localparam int SIEVE_LIMIT   = 10000;

    localparam int DIM_W   = 11;
    localparam int IDX_W   = 48;
    localparam int FRAC_W  = 32;
    localparam int PRIME_W = 14;
    localparam int ACC_W   = 64;
    localparam int N_W     = INDEX_BITS + 1;

    localparam int MARK_AW = $clog2(SIEVE_LIMIT + 1);
    localparam int MARK_BW = MARK_AW + 1;
    localparam int TBL_AW  = $clog2(PRIME_COUNT);
    localparam int KCNT_W  = $clog2(PRIME_COUNT + 1);
    localparam int STEP_W  = $clog2((N_W > FRACTION_BITS) ? N_W : FRACTION_BITS);

    localparam int S_DATA_W = ((DIM_W + IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = FRAC_W;

    typedef struct packed {
        logic clr;
        logic scan_rd;
        logic scan_chk;
        logic mark;
        logic accept;
        logic load;
        logic dig_init;
        logic div_step;
        logic dig_end;
        logic frac_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic unmarked;
        logic sq_ok;
        logic mark_last;
        logic dim_bad;
        logic div_last;
        logic quot_zero;
        logic frac_last;
        logic out_free;
    } sts_t;

endpackage

/* design/shs_ctrl.sv */
// ----------------------------------------------------------------------------
// shs_ctrl: sequencer for the scrambled Halton sampler
// Runs the prime sieve after reset, then steps each request with a valid
// dimension through digit extraction and the final fraction division.
// ----------------------------------------------------------------------------
module shs_ctrl import shs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b000_0000_0001,
        ST_SCAN_RD  = 11'b000_0000_0010,
        ST_SCAN_CHK = 11'b000_0000_0100,
        ST_MARK     = 11'b000_0000_1000,
        ST_IDLE     = 11'b000_0001_0000,
        ST_LOAD     = 11'b000_0010_0000,
        ST_DIG_INIT = 11'b000_0100_0000,
        ST_DIV      = 11'b000_1000_0000,
        ST_DIG_END  = 11'b001_0000_0000,
        ST_FRAC     = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                cmd.scan_chk = 1'b1;
                if (sts.unmarked && sts.sq_ok) state_next = ST_MARK;
                else if (sts.scan_last)        state_next = ST_IDLE;
                else                           state_next = ST_SCAN_RD;
            end
            ST_MARK: begin
                cmd.mark = 1'b1;
                if (sts.mark_last) state_next = ST_SCAN_RD;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = sts.dim_bad ? ST_DONE : ST_DIG_INIT;
            end
            ST_DIG_INIT: begin
                cmd.dig_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_DIG_END;
            end
            ST_DIG_END: begin
                cmd.dig_end = 1'b1;
                state_next  = sts.quot_zero ? ST_FRAC : ST_DIG_INIT;
            end
            ST_FRAC: begin
                cmd.frac_step = 1'b1;
                if (sts.frac_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

/* design/shs_dp.sv */
// ----------------------------------------------------------------------------
// shs_dp: datapath for the scrambled Halton sampler
// Sieve and prime table memories, radix-p digit divider with serial
// multipliers for numerator/denominator, fraction divider, output register.
// ----------------------------------------------------------------------------
module shs_dp import shs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser
);

    // sieve state
    logic [MARK_AW-1:0] c_reg;
    logic [MARK_BW-1:0] b_reg;
    logic [KCNT_W-1:0]  k_reg;
    logic               mark_mem [SIEVE_LIMIT+1];
    logic               mark_rd_reg;
    logic [PRIME_W-1:0] tbl_mem [PRIME_COUNT];
    logic [PRIME_W-1:0] tbl_rd_reg;

    // sample state
    logic [DIM_W-1:0]         dim_reg;
    logic [PRIME_W-1:0]       p_reg;
    logic [PRIME_W-1:0]       rem_reg;
    logic [N_W-1:0]           quot_reg;
    logic [STEP_W-1:0]        cnt_reg;
    logic [ACC_W-1:0]         num_reg, den_reg, nacc_reg, dacc_reg, mnum_reg, mden_reg;
    logic [PRIME_W-1:0]       mp_reg;
    logic [FRACTION_BITS-1:0] q_reg;
    logic                     bad_reg;
    logic                     m_tvalid_reg;
    logic [M_DATA_W-1:0]      m_frac_reg;
    logic                     m_bad_reg;

    logic [2*MARK_AW-1:0] c_sq;
    logic [MARK_BW-1:0]   b_step;
    logic                 go_mark;
    logic [DIM_W-1:0]     in_dim;
    logic [IDX_W-1:0]     in_idx;
    logic [PRIME_W:0]     rem_sh, rem_sub;
    logic                 div_ge;
    logic [PRIME_W-1:0]   rem_next;
    logic [PRIME_W-1:0]   digit;
    logic [ACC_W-1:0]     num_sh;
    logic                 fr_ge;

    assign in_dim = s_tdata[DIM_W-1:0];
    assign in_idx = s_tdata[DIM_W+IDX_W-1:DIM_W];

    assign c_sq    = c_reg * c_reg;
    assign b_step  = b_reg + MARK_BW'(c_reg);
    assign go_mark = !mark_rd_reg && (c_sq <= (2*MARK_AW)'(SIEVE_LIMIT));

    // restoring division step, one quotient bit per cycle
    assign rem_sh   = {rem_reg, quot_reg[N_W-1]};
    assign rem_sub  = rem_sh - {1'b0, p_reg};
    assign div_ge   = (rem_sh >= {1'b0, p_reg});
    assign rem_next = div_ge ? rem_sub[PRIME_W-1:0] : rem_sh[PRIME_W-1:0];
    // scrambled digit: nonzero x maps to p - x
    assign digit    = (rem_reg == '0) ? '0 : (p_reg - rem_reg);

    assign num_sh = {num_reg[ACC_W-2:0], 1'b0};
    assign fr_ge  = (num_sh >= den_reg);

    always_comb begin
        sts           = '0;
        sts.clr_last  = (c_reg == MARK_AW'(SIEVE_LIMIT));
        sts.scan_last = (c_reg == MARK_AW'(SIEVE_LIMIT));
        sts.unmarked  = !mark_rd_reg;
        sts.sq_ok     = (c_sq <= (2*MARK_AW)'(SIEVE_LIMIT));
        sts.mark_last = (b_step > MARK_BW'(SIEVE_LIMIT));
        sts.dim_bad   = (dim_reg >= DIM_W'(PRIME_COUNT));
        sts.div_last  = (cnt_reg == STEP_W'(N_W - 1));
        sts.quot_zero = (quot_reg == '0);
        sts.frac_last = (cnt_reg == STEP_W'(FRACTION_BITS - 1));
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    // sieve marks: one port, write or read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            mark_mem[c_reg] <= 1'b0;
        end
        if (cmd.mark) begin
            mark_mem[b_reg[MARK_AW-1:0]] <= 1'b1;
        end
        if (cmd.scan_rd) begin
            mark_rd_reg <= mark_mem[c_reg];
        end
    end

    // prime table
    always_ff @(posedge aclk) begin
        if (cmd.scan_chk && !mark_rd_reg && (k_reg < KCNT_W'(PRIME_COUNT))) begin
            tbl_mem[k_reg[TBL_AW-1:0]] <= PRIME_W'(c_reg);
        end
        if (cmd.accept) begin
            tbl_rd_reg <= tbl_mem[in_dim[TBL_AW-1:0]];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg        <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clr) begin
                c_reg <= (c_reg == MARK_AW'(SIEVE_LIMIT)) ? MARK_AW'(2) : c_reg + 1'b1;
            end
            if (cmd.scan_chk) begin
                if (!mark_rd_reg && (k_reg < KCNT_W'(PRIME_COUNT))) k_reg <= k_reg + 1'b1;
                if (!go_mark) c_reg <= c_reg + 1'b1;
            end
            if (cmd.mark && (b_step > MARK_BW'(SIEVE_LIMIT))) begin
                c_reg <= c_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.scan_chk && go_mark) begin
            b_reg <= MARK_BW'(c_sq);
        end
        if (cmd.mark) begin
            b_reg <= b_step;
        end
        if (cmd.accept) begin
            dim_reg  <= in_dim;
            quot_reg <= N_W'(in_idx[INDEX_BITS-1:0]) + 1'b1;
        end
        if (cmd.load) begin
            p_reg   <= tbl_rd_reg;
            num_reg <= '0;
            den_reg <= ACC_W'(1);
            q_reg   <= '0;
            bad_reg <= (dim_reg >= DIM_W'(PRIME_COUNT));
        end
        if (cmd.dig_init) begin
            rem_reg  <= '0;
            cnt_reg  <= '0;
            nacc_reg <= '0;
            dacc_reg <= '0;
            mnum_reg <= num_reg;
            mden_reg <= den_reg;
            mp_reg   <= p_reg;
        end
        if (cmd.div_step) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[N_W-2:0], div_ge};
            cnt_reg  <= cnt_reg + 1'b1;
            // shift-add products num*p and den*p ride along
            if (mp_reg[0]) begin
                nacc_reg <= nacc_reg + mnum_reg;
                dacc_reg <= dacc_reg + mden_reg;
            end
            mnum_reg <= {mnum_reg[ACC_W-2:0], 1'b0};
            mden_reg <= {mden_reg[ACC_W-2:0], 1'b0};
            mp_reg   <= mp_reg >> 1;
        end
        if (cmd.dig_end) begin
            num_reg <= nacc_reg + ACC_W'(digit);
            den_reg <= dacc_reg;
            cnt_reg <= '0;
        end
        if (cmd.frac_step) begin
            num_reg <= fr_ge ? (num_sh - den_reg) : num_sh;
            q_reg   <= {q_reg[FRACTION_BITS-2:0], fr_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.out_load) begin
            m_frac_reg <= M_DATA_W'(q_reg);
            m_bad_reg  <= bad_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_frac_reg;
    assign m_tuser  = m_bad_reg;

endmodule

/* design/scrambled_halton_sample.sv */
// ----------------------------------------------------------------------------
// scrambled_halton_sample: scrambled radical-inverse sample generator
// Picks the prime for a dimension, writes index+1 in that base with each
// nonzero digit x replaced by p-x, mirrors the digits behind the point
// and returns the truncated 0.32 fraction.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  s_      | in  | s_tvalid / s_tready | tdata: dimension[10:0], sample_index[58:11]
//  m_      | out | m_tvalid / m_tready | tdata: fraction[31:0]; tuser: bad_dimension
//
//  Each base-p digit of index+1 takes one 49-step restoring division by p,
//  with products num*p and den*p accumulating serially under it; the
//  fraction division follows once the quotient reaches zero.
//  Bad dimension: the digit and fraction steps are skipped, fraction 0.
//  Reset: the sieve clears 10001 marks, scans and strikes multiples to fill
//  the prime table, with s_tready low throughout.
//  Stalls: one request at a time; a finished result waits in the output
//  register while the next request is accepted and worked on.
//
module scrambled_halton_sample import shs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // dimension[10:0], sample_index[58:11], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // fraction[31:0]
    output logic                m_tuser    // bad_dimension
);

    cmd_t cmd;
    sts_t sts;

    shs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    shs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
